FILE: hw/rtl/idq_pkg.sv
// Package for the indexed deque: request and response types, operation and status codes.
`default_nettype none

package idq_pkg;

   // Default sizing handed to the top level
   localparam int DEPTH_DEFAULT      = 16;
   localparam int ITEM_WIDTH_DEFAULT = 32;

   // Operation codes
   localparam logic [2:0] OP_INSERT_FRONT = 3'd0;
   localparam logic [2:0] OP_INSERT_BACK  = 3'd1;
   localparam logic [2:0] OP_REMOVE_FRONT = 3'd2;
   localparam logic [2:0] OP_REMOVE_BACK  = 3'd3;
   localparam logic [2:0] OP_READ_AT      = 3'd4;
   localparam logic [2:0] OP_REMOVE_AT    = 3'd5;

   // Status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] item;
      logic [3:0]  position;
   } req_type;

   typedef struct packed {
      logic [31:0] item_out;
      logic [3:0]  slot;
      logic [1:0]  status;
      logic [4:0]  count;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hw/rtl/idq_ram.sv
// Entry store of the indexed deque: one write port, one registered read port.
`default_nettype none

module idq_ram #(
   parameter  int DEPTH = 16,
   parameter  int WIDTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered: data in the cycle after the address is taken
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_deque_top.sv
// Top level of the indexed deque: request decode, circular indexing and the shift sequencer.
`default_nettype none

// Bounded double-ended queue of handles in a circular store of DEPTH entries. A request
// is taken when start is high and busy is low; its result shows on rsp_data for one
// cycle with rsp_strobe, and the receiver cannot stall it. Inserts and refused requests
// answer in the cycle after acceptance and a new request may follow at once. Removes
// and reads go through the store's registered read port and the READ state, so the result
// strobes after that state and busy is high while in it. A remove at a position then
// closes the gap one entry per cycle via the store's write and read ports; busy stays high
// in SHIFT until all (count - 1 - position) later entries, up to DEPTH - 1, have moved.

module indexed_deque_top
   import idq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int ITEM_WIDTH = ITEM_WIDTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int PW = (CW > 4) ? CW : 4;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_READ  = 3'b010,
      ST_SHIFT = 3'b100
   } state_type;

   state_type       state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   rem_ff, rem_in;
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   rsp_type         rsp_ff, rsp_in;
   logic            strobe_ff, strobe_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   logic                  accept;
   logic                  is_full;
   logic                  is_empty;
   logic                  pos_bad;
   logic [CW-1:0]         ipos;
   logic [AW-1:0]         pos_phys;

   // Circular index helpers
   function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] dec_ptr(input logic [AW-1:0] p);
      return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
   endfunction

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                          input logic [CW-1:0] off);
      logic [SW-1:0] s;
      s = SW'(base) + SW'(off);
      if (s >= SW'(DEPTH)) begin
         s = s - SW'(DEPTH);
      end
      return AW'(s);
   endfunction

   idq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (ITEM_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // Request checks
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign pos_bad  = (PW'(req_data.position) >= PW'(count_ff));
   assign ipos     = CW'(req_data.position);
   assign pos_phys = phys(head_ff, ipos);

   // Next state, store access and response
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      rsp_in    = rsp_ff;
      strobe_in = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = wr_ptr_ff;
      wr_data   = rd_data;
      rd_en     = 1'b0;
      rd_addr   = rd_ptr_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_in.item_out = '0;
               rsp_in.slot     = '0;
               rsp_in.status   = STATUS_DONE;
               rsp_in.count    = 5'(count_ff);
               rem_in          = '0;
               case (req_data.operation)
                  OP_INSERT_FRONT: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        head_in      = dec_ptr(head_ff);
                        wr_en        = 1'b1;
                        wr_addr      = dec_ptr(head_ff);
                        wr_data      = ITEM_WIDTH'(req_data.item);
                        count_in     = count_ff + CW'(1);
                        rsp_in.count = 5'(count_ff + CW'(1));
                     end
                  end
                  OP_INSERT_BACK: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_in.slot   = 4'(count_ff - CW'(1));
                     end else begin
                        wr_en        = 1'b1;
                        wr_addr      = phys(head_ff, count_ff);
                        wr_data      = ITEM_WIDTH'(req_data.item);
                        count_in     = count_ff + CW'(1);
                        rsp_in.slot  = 4'(count_ff);
                        rsp_in.count = 5'(count_ff + CW'(1));
                     end
                  end
                  OP_REMOVE_FRONT: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = head_ff;
                        head_in      = inc_ptr(head_ff);
                        count_in     = count_ff - CW'(1);
                        rsp_in.count = 5'(count_ff - CW'(1));
                        state_in     = ST_READ;
                     end
                  end
                  OP_REMOVE_BACK: begin
                     if (is_empty) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = phys(head_ff, count_ff - CW'(1));
                        count_in     = count_ff - CW'(1);
                        rsp_in.slot  = 4'(count_ff - CW'(1));
                        rsp_in.count = 5'(count_ff - CW'(1));
                        state_in     = ST_READ;
                     end
                  end
                  OP_READ_AT: begin
                     rsp_in.slot = req_data.position;
                     if (pos_bad) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_phys;
                        state_in = ST_READ;
                     end
                  end
                  OP_REMOVE_AT: begin
                     rsp_in.slot = req_data.position;
                     if (pos_bad) begin
                        strobe_in     = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        rd_en        = 1'b1;
                        rd_addr      = pos_phys;
                        count_in     = count_ff - CW'(1);
                        rsp_in.count = 5'(count_ff - CW'(1));
                        // entries after the removed one move down by one place
                        rem_in       = count_ff - CW'(1) - ipos;
                        wr_ptr_in    = pos_phys;
                        rd_ptr_in    = inc_ptr(pos_phys);
                        state_in     = ST_READ;
                     end
                  end
                  default: begin
                     strobe_in     = 1'b1;
                     rsp_in.status = STATUS_EMPTY;
                  end
               endcase
            end
         end
         ST_READ: begin
            // store data is back: answer, then start the close-up if one is due
            strobe_in       = 1'b1;
            rsp_in.item_out = 32'(rd_data);
            if (rem_ff != '0) begin
               rd_en    = 1'b1;
               rd_addr  = rd_ptr_ff;
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SHIFT: begin
            // write back the entry read last cycle one place lower, read the next
            wr_en     = 1'b1;
            wr_addr   = wr_ptr_ff;
            wr_data   = rd_data;
            wr_ptr_in = rd_ptr_ff;
            rem_in    = rem_ff - CW'(1);
            if (rem_ff > CW'(1)) begin
               rd_en     = 1'b1;
               rd_addr   = inc_ptr(rd_ptr_ff);
               rd_ptr_in = inc_ptr(rd_ptr_ff);
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload and sequencer registers
   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      rem_ff    <= rem_in;
      wr_ptr_ff <= wr_ptr_in;
      rd_ptr_ff <= rd_ptr_in;
   end

endmodule

`default_nettype wire

FILE: tb/sv/indexed_deque_top_tb.sv
// Self-checking testbench for the indexed deque: queue-fed driver, shadow-list predictor, monitor.
`default_nettype none

module indexed_deque_top_tb
   import idq_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = DEPTH_DEFAULT;
   localparam int ITEM_WIDTH   = ITEM_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = DEPTH + 8;

   // Codes outside the defined operation set; the block must refuse them
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   typedef struct {
      req_type     req;
      int unsigned idle_pct;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   indexed_deque_top #(
      .DEPTH      (DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #2 clock = ~clock;

   pending_type  pending_q[$];
   rsp_type      expected_rsp_q[$];
   pending_type  next_entry;
   rsp_type      want_rsp;
   int unsigned  fail_count = 0;
   int unsigned  queued_count = 0;
   int unsigned  gen_count = 0;
   int unsigned  op_hits[8];
   int unsigned  status_hits[4];

   // Shadow copy of the list
   logic [31:0]  shadow_store [DEPTH];
   logic [3:0]   shadow_head = '0;
   logic [4:0]   shadow_count = '0;

   // Store index of a list position
   function automatic logic [3:0] shadow_index(logic [4:0] pos);
      return 4'(shadow_head + pos);
   endfunction

   // Apply one request to the shadow list and return the response it should give
   function automatic rsp_type predict_response(req_type rq);
      rsp_type     r;
      logic [4:0]  i;
      r = '0;
      r.status = STATUS_DONE;
      case (rq.operation)
         OP_INSERT_FRONT: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_head = shadow_head - 4'd1;
               shadow_store[shadow_head] = rq.item;
               shadow_count = shadow_count + 5'd1;
            end
         end
         OP_INSERT_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               shadow_store[shadow_index(shadow_count)] = rq.item;
               shadow_count = shadow_count + 5'd1;
            end
            r.slot = 4'(shadow_count - 5'd1);
         end
         OP_REMOVE_FRONT: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.item_out = shadow_store[shadow_head];
               shadow_head = shadow_head + 4'd1;
               shadow_count = shadow_count - 5'd1;
            end
         end
         OP_REMOVE_BACK: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               shadow_count = shadow_count - 5'd1;
               r.item_out = shadow_store[shadow_index(shadow_count)];
               r.slot = 4'(shadow_count);
            end
         end
         OP_READ_AT: begin
            r.slot = rq.position;
            if (5'(rq.position) >= shadow_count) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.item_out = shadow_store[shadow_index(5'(rq.position))];
            end
         end
         OP_REMOVE_AT: begin
            r.slot = rq.position;
            if (5'(rq.position) >= shadow_count) begin
               r.status = STATUS_EMPTY;
            end else begin
               r.item_out = shadow_store[shadow_index(5'(rq.position))];
               // later entries close up by one place
               for (i = 5'(rq.position); i + 5'd1 < shadow_count; i++) begin
                  shadow_store[shadow_index(i)] = shadow_store[shadow_index(i + 5'd1)];
               end
               shadow_count = shadow_count - 5'd1;
            end
         end
         default: begin
            r.status = STATUS_EMPTY;
         end
      endcase
      r.count = shadow_count;
      return r;
   endfunction

   // Queue one request; the idle rate follows the phase the request falls in
   task automatic queue_request(logic [2:0] op, logic [31:0] item, logic [3:0] pos);
      pending_type  e;
      int unsigned  phase;
      phase = (queued_count / 120) % 4;
      e.req.operation = op;
      e.req.item = item;
      e.req.position = pos;
      case (phase)
         1: e.idle_pct = 66;
         3: e.idle_pct = 16;
         default: e.idle_pct = 0;
      endcase
      pending_q.push_back(e);
      queued_count++;
      // fill level tracked only to steer the random mix
      case (op)
         OP_INSERT_FRONT, OP_INSERT_BACK: if (gen_count < DEPTH) gen_count++;
         OP_REMOVE_FRONT, OP_REMOVE_BACK: if (gen_count > 0) gen_count--;
         OP_REMOVE_AT: if (pos < gen_count) gen_count--;
         default: ;
      endcase
   endtask

   // Directed corner cases, then random bursts steered toward a fill target
   task automatic build_stimulus();
      int unsigned target;
      int unsigned len;
      int unsigned r;
      logic [2:0]  op;
      logic [31:0] item;
      logic [3:0]  pos;
      // empty list and undefined codes
      queue_request(OP_REMOVE_FRONT, 32'hFFFF_FFFF, 4'd0);
      queue_request(OP_REMOVE_BACK,  32'hFFFF_FFFF, 4'd15);
      queue_request(OP_READ_AT,      32'h0,         4'd0);
      queue_request(OP_REMOVE_AT,    32'h0,         4'd15);
      queue_request(OP_UNUSED_6,     32'hFFFF_FFFF, 4'd15);
      queue_request(OP_UNUSED_7,     32'h1234_5678, 4'd3);
      // small list, reads in and past range
      queue_request(OP_INSERT_BACK,  32'h0,         4'd15);
      queue_request(OP_INSERT_BACK,  32'hFFFF_FFFF, 4'd0);
      queue_request(OP_INSERT_FRONT, 32'hA5A5_5A5A, 4'd7);
      queue_request(OP_READ_AT,      32'h0,         4'd0);
      queue_request(OP_READ_AT,      32'h0,         4'd1);
      queue_request(OP_READ_AT,      32'h0,         4'd2);
      queue_request(OP_READ_AT,      32'h0,         4'd3);
      queue_request(OP_READ_AT,      32'h0,         4'd15);
      // middle removal, then down to a single entry and empty
      queue_request(OP_REMOVE_AT,    32'h0,         4'd1);
      queue_request(OP_REMOVE_AT,    32'h0,         4'd2);
      queue_request(OP_REMOVE_BACK,  32'h0,         4'd0);
      queue_request(OP_REMOVE_FRONT, 32'h0,         4'd0);
      queue_request(OP_INSERT_FRONT, 32'h8000_0001, 4'd0);
      queue_request(OP_REMOVE_AT,    32'h0,         4'd0);
      queue_request(OP_REMOVE_AT,    32'h0,         4'd0);

      while (queued_count < 21 + RANDOM_ITEMS) begin
         r = $urandom_range(9);
         if (r < 2) target = DEPTH;
         else if (r < 4) target = 0;
         else target = $urandom_range(DEPTH);
         len = $urandom_range(40, 12);
         repeat (len) begin
            r = $urandom_range(99);
            if (r < 3) op = r[0] ? OP_UNUSED_6 : OP_UNUSED_7;
            else if (r < 15) op = OP_READ_AT;
            else if (gen_count < target ? r < 75 : r < 30)
               op = $urandom_range(1) ? OP_INSERT_BACK : OP_INSERT_FRONT;
            else begin
               case ($urandom_range(2))
                  0: op = OP_REMOVE_FRONT;
                  1: op = OP_REMOVE_BACK;
                  default: op = OP_REMOVE_AT;
               endcase
            end
            if (gen_count > 0 && $urandom_range(9) < 8) pos = 4'($urandom_range(gen_count - 1));
            else pos = 4'($urandom_range(15));
            case ($urandom_range(9))
               0: item = '0;
               1: item = '1;
               default: item = $urandom;
            endcase
            queue_request(op, item, pos);
         end
      end
   endtask

   // Driver: hold a request while busy, otherwise present the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsp_q.push_back(predict_response(req_data));
         end
         if (!start || !busy) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
               next_entry = pending_q.pop_front();
               req_data <= next_entry.req;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: each strobed response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            $error("response with none expected: item_out %0h slot %0d status %0d count %0d",
                   rsp_data.item_out, rsp_data.slot, rsp_data.status, rsp_data.count);
            fail_count++;
         end else begin
            want_rsp = expected_rsp_q.pop_front();
            if (rsp_data.item_out !== want_rsp.item_out) begin
               $error("item_out: expected %0h, got %0h", want_rsp.item_out, rsp_data.item_out);
               fail_count++;
            end
            if (rsp_data.slot !== want_rsp.slot) begin
               $error("slot: expected %0d, got %0d", want_rsp.slot, rsp_data.slot);
               fail_count++;
            end
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.count !== want_rsp.count) begin
               $error("count: expected %0d, got %0d", want_rsp.count, rsp_data.count);
               fail_count++;
            end
            status_hits[want_rsp.status]++;
         end
      end
   end

   // Tally of accepted requests by operation
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         op_hits[req_data.operation]++;
      end
   end

   // Main sequence: reset, run all requests, drain, report
   initial begin
      build_stimulus();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || start || expected_rsp_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp_q.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp_q.size());
         fail_count++;
      end
      $display("Ran %0d requests: %0d inserts, %0d end removes, %0d reads, %0d indexed removes,",
               queued_count, op_hits[OP_INSERT_FRONT] + op_hits[OP_INSERT_BACK],
               op_hits[OP_REMOVE_FRONT] + op_hits[OP_REMOVE_BACK], op_hits[OP_READ_AT],
               op_hits[OP_REMOVE_AT]);
      $display("%0d undefined codes; %0d refused as full, %0d as empty or out of range.",
               op_hits[OP_UNUSED_6] + op_hits[OP_UNUSED_7], status_hits[STATUS_FULL],
               status_hits[STATUS_EMPTY]);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
